### sv/particle_lifetime_integrator_macros.svh
// assertion helpers, clocked on clk and quiet in reset
`ifndef PARTICLE_LIFETIME_INTEGRATOR_MACROS_SVH
`define PARTICLE_LIFETIME_INTEGRATOR_MACROS_SVH

// condition must never hold
`define PLI_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// next-cycle implication
`define PLI_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/pli_pkg.sv
package pli_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ONE_I     = 1 << FRAC_BITS;
  localparam int HALF_I    = 1 << (FRAC_BITS - 1);

  // pipeline stage map
  localparam int ST_LIFE = 0;
  localparam int ST_VEL  = 1;
  localparam int ST_DRAG = 2;
  localparam int ST_POS  = 3;
  localparam int ST_DIV0 = 4;
  localparam int ST_T    = ST_DIV0 + FRAC_BITS;
  localparam int ST_EASE = ST_T + 1;
  localparam int ST_SIZE = ST_T + 2;
  localparam int NST     = ST_T + 3;

  // register indexes
  localparam logic [1:0] CFG_FRAME_TIME = 2'd0;
  localparam logic [1:0] CFG_GRAVITY    = 2'd1;
  localparam logic [1:0] CFG_DRAG       = 2'd2;
  localparam logic [1:0] CFG_CURVE      = 2'd3;

  // easing curves
  localparam logic [2:0] CRV_LINEAR   = 3'd0;
  localparam logic [2:0] CRV_IN_QUAD  = 3'd1;
  localparam logic [2:0] CRV_OUT_QUAD = 3'd2;
  localparam logic [2:0] CRV_IO_QUAD  = 3'd3;
  localparam logic [2:0] CRV_OUT_CUB  = 3'd4;
  localparam logic [2:0] CRV_IN_CUB   = 3'd5;

  typedef logic signed [47:0]          wd_t;
  typedef logic signed [FRAC_BITS+4:0] es_t;

  typedef struct packed {
    logic signed [31:0]   px;
    logic signed [31:0]   py;
    logic signed [31:0]   vx;
    logic signed [31:0]   vy;
    logic signed [31:0]   ang;
    logic signed [31:0]   rate;
    logic signed [31:0]   life;
    logic [30:0]          total;
    logic [30:0]          sbeg;
    logic signed [31:0]   sfin;
    wd_t                  g;
    wd_t                  d;
    wd_t                  am;
    logic [FRAC_BITS:0]   f;
    logic                 tot0;
    logic                 tge;
    logic [30:0]          rem;
    logic [FRAC_BITS-1:0] q;
    es_t                  t;
    es_t                  u;
    es_t                  p1;
    es_t                  p2;
    es_t                  p3;
    es_t                  pu;
    logic [FRAC_BITS:0]   e;
    logic signed [31:0]   size;
  } st_t;

  // rounded fixed point product, half up
  function automatic logic signed [65:0] mulq(input logic signed [32:0] a,
                                              input logic signed [32:0] b);
    logic signed [65:0] p;
    p = 66'(a) * 66'(b);
    p = p + 66'(HALF_I);
    return p >>> FRAC_BITS;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

### sv/particle_lifetime_integrator.sv
// throughput: one particle per cycle while in_stall is low; the restoring divider
// for life progress takes one quotient bit per stage and sets the pipeline depth
// dead particles are dropped after the first stage and leave a bubble
// reset (rst_n low, synchronous) empties the pipeline and loads frame_time 1092,
// gravity 0, drag 0, linear size curve
`include "particle_lifetime_integrator_macros.svh"

module particle_lifetime_integrator
  import pli_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  // particle requests
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic signed [31:0] in_spin_angle,
  input  logic signed [31:0] in_spin_rate,
  input  logic signed [31:0] in_life_left,
  input  logic [30:0]        in_life_total,
  input  logic [30:0]        in_size_begin,
  input  logic signed [31:0] in_size_finish,
  // updated particles
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_new_pos_x,
  output logic signed [31:0] out_new_pos_y,
  output logic signed [31:0] out_new_vel_x,
  output logic signed [31:0] out_new_vel_y,
  output logic signed [31:0] out_new_spin_angle,
  output logic signed [31:0] out_spin_rate,
  output logic [30:0]        out_new_life_left,
  output logic [30:0]        out_life_total,
  output logic [30:0]        out_size_begin,
  output logic signed [31:0] out_size_finish,
  output logic signed [31:0] out_current_size
);

  // configuration registers
  logic [20:0]        frame_time_r;
  logic signed [31:0] gravity_r;
  logic [22:0]        drag_r;
  logic [2:0]         curve_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_time_r <= 21'd1092;
      gravity_r    <= '0;
      drag_r       <= '0;
      curve_r      <= CRV_LINEAR;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRAME_TIME: frame_time_r <= cfg_wdata[20:0];
        CFG_GRAVITY:    gravity_r    <= cfg_wdata;
        CFG_DRAG:       drag_r       <= cfg_wdata[22:0];
        CFG_CURVE:      curve_r      <= cfg_wdata[2:0];
      endcase
    end
  end

  // frame step as a signed multiplier operand
  logic signed [32:0] dt_s;
  assign dt_s = 33'($signed({1'b0, frame_time_r}));

  // pipeline: valid bits travel with each stage, bubbles collapse
  logic [NST-1:0] vld_r;
  logic [NST-1:0] vld_nxt;
  logic [NST-1:0] en;
  st_t            st_r   [NST];
  st_t            st_nxt [NST];

  // a stage may load when empty or when its content moves on
  always_comb begin
    en[NST-1] = !vld_r[NST-1] || !out_stall;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  assign in_stall = !en[0];

  always_comb begin
    logic [31:0] rem2;
    logic [31:0] tot_x;
    es_t         t;
    es_t         u;
    es_t         ev;
    wd_t         fw;
    logic signed [32:0] diff;
    for (int i = 0; i < NST; i++) begin
      if (i == 0) begin
        st_nxt[i]  = st_r[0];
        vld_nxt[i] = in_valid;
      end else begin
        st_nxt[i]  = st_r[i-1];
        vld_nxt[i] = vld_r[i-1];
      end
    end

    // stage 0: products with dt, lifetime step
    st_nxt[ST_LIFE].px    = in_pos_x;
    st_nxt[ST_LIFE].py    = in_pos_y;
    st_nxt[ST_LIFE].vx    = in_vel_x;
    st_nxt[ST_LIFE].vy    = in_vel_y;
    st_nxt[ST_LIFE].ang   = in_spin_angle;
    st_nxt[ST_LIFE].rate  = in_spin_rate;
    st_nxt[ST_LIFE].total = in_life_total;
    st_nxt[ST_LIFE].sbeg  = in_size_begin;
    st_nxt[ST_LIFE].sfin  = in_size_finish;
    st_nxt[ST_LIFE].g     = wd_t'(mulq(33'(gravity_r), dt_s));
    st_nxt[ST_LIFE].d     = wd_t'(mulq(33'($signed({1'b0, drag_r})), dt_s));
    st_nxt[ST_LIFE].am    = wd_t'(mulq(33'(in_spin_rate), dt_s));
    st_nxt[ST_LIFE].life  = sat32(66'(in_life_left) - 66'(dt_s));

    // stage 1: gravity, damping factor, angle, drop dead particles, divider setup
    vld_nxt[ST_VEL]      = vld_r[ST_LIFE] && (st_r[ST_LIFE].life > 32'sd0);
    st_nxt[ST_VEL].vy    = sat32(66'(st_r[ST_LIFE].vy) + 66'(st_r[ST_LIFE].g));
    st_nxt[ST_VEL].ang   = sat32(66'(st_r[ST_LIFE].ang) + 66'(st_r[ST_LIFE].am));
    fw = wd_t'(ONE_I) - st_r[ST_LIFE].d;
    if (fw < 0) st_nxt[ST_VEL].f = '0;
    else st_nxt[ST_VEL].f = fw[FRAC_BITS:0];
    st_nxt[ST_VEL].tot0  = (st_r[ST_LIFE].total == '0);
    st_nxt[ST_VEL].tge   = ({1'b0, st_r[ST_LIFE].total} <= st_r[ST_LIFE].life[31:0]);
    st_nxt[ST_VEL].rem   = st_r[ST_LIFE].life[30:0];
    st_nxt[ST_VEL].q     = '0;

    // stage 2: velocity damping
    if (drag_r != '0) begin
      st_nxt[ST_DRAG].vx = sat32(mulq(33'(st_r[ST_VEL].vx),
                                      33'($signed({1'b0, st_r[ST_VEL].f}))));
      st_nxt[ST_DRAG].vy = sat32(mulq(33'(st_r[ST_VEL].vy),
                                      33'($signed({1'b0, st_r[ST_VEL].f}))));
    end

    // stage 3: position integration
    st_nxt[ST_POS].px = sat32(66'(st_r[ST_DRAG].px) + mulq(33'(st_r[ST_DRAG].vx), dt_s));
    st_nxt[ST_POS].py = sat32(66'(st_r[ST_DRAG].py) + mulq(33'(st_r[ST_DRAG].vy), dt_s));

    // restoring divider, one quotient bit per stage
    for (int k = 0; k < FRAC_BITS; k++) begin
      rem2  = {st_r[ST_DIV0+k-1].rem, 1'b0};
      tot_x = {1'b0, st_r[ST_DIV0+k-1].total};
      if (rem2 >= tot_x) begin
        st_nxt[ST_DIV0+k].rem = 31'(rem2 - tot_x);
        st_nxt[ST_DIV0+k].q   = {st_r[ST_DIV0+k-1].q[FRAC_BITS-2:0], 1'b1};
      end else begin
        st_nxt[ST_DIV0+k].rem = rem2[30:0];
        st_nxt[ST_DIV0+k].q   = {st_r[ST_DIV0+k-1].q[FRAC_BITS-2:0], 1'b0};
      end
    end

    // life progress and squares
    if (st_r[ST_T-1].tot0) t = es_t'(ONE_I);
    else if (st_r[ST_T-1].tge) t = '0;
    else t = es_t'(ONE_I) - es_t'(st_r[ST_T-1].q);
    u = es_t'(ONE_I) - t;
    st_nxt[ST_T].t  = t;
    st_nxt[ST_T].u  = u;
    st_nxt[ST_T].p1 = es_t'(mulq(33'(t), 33'(t)));
    st_nxt[ST_T].p2 = es_t'(mulq(33'(t), 33'(es_t'(2 * ONE_I) - t)));
    st_nxt[ST_T].p3 = es_t'(mulq(33'(es_t'(4 * ONE_I) - t - t), 33'(t)));
    st_nxt[ST_T].pu = es_t'(mulq(33'(u), 33'(u)));

    // easing select, cubes, clamp to [0, 1]
    unique case (curve_r)
      CRV_IN_QUAD:  ev = st_r[ST_T].p1;
      CRV_OUT_QUAD: ev = st_r[ST_T].p2;
      CRV_IO_QUAD: begin
        if (st_r[ST_T].t < es_t'(HALF_I)) ev = st_r[ST_T].p1 + st_r[ST_T].p1;
        else ev = st_r[ST_T].p3 - es_t'(ONE_I);
      end
      CRV_OUT_CUB:  ev = es_t'(ONE_I) - es_t'(mulq(33'(st_r[ST_T].pu), 33'(st_r[ST_T].u)));
      CRV_IN_CUB:   ev = es_t'(mulq(33'(st_r[ST_T].p1), 33'(st_r[ST_T].t)));
      default:      ev = st_r[ST_T].t;
    endcase
    if (ev < 0) st_nxt[ST_EASE].e = '0;
    else if (ev > es_t'(ONE_I)) st_nxt[ST_EASE].e = (FRAC_BITS+1)'(ONE_I);
    else st_nxt[ST_EASE].e = ev[FRAC_BITS:0];

    // size blend
    diff = 33'(st_r[ST_EASE].sfin) - 33'($signed({1'b0, st_r[ST_EASE].sbeg}));
    st_nxt[ST_SIZE].size = sat32(66'($signed({1'b0, st_r[ST_EASE].sbeg}))
                                 + mulq(diff, 33'($signed({1'b0, st_r[ST_EASE].e}))));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (en[i]) vld_r[i] <= vld_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NST; i++) begin
      if (en[i]) st_r[i] <= st_nxt[i];
    end
  end

  // last stage is the output register
  assign out_valid          = vld_r[NST-1];
  assign out_new_pos_x      = st_r[NST-1].px;
  assign out_new_pos_y      = st_r[NST-1].py;
  assign out_new_vel_x      = st_r[NST-1].vx;
  assign out_new_vel_y      = st_r[NST-1].vy;
  assign out_new_spin_angle = st_r[NST-1].ang;
  assign out_spin_rate      = st_r[NST-1].rate;
  assign out_new_life_left  = st_r[NST-1].life[30:0];
  assign out_life_total     = st_r[NST-1].total;
  assign out_size_begin     = st_r[NST-1].sbeg;
  assign out_size_finish    = st_r[NST-1].sfin;
  assign out_current_size   = st_r[NST-1].size;

  // a delivered particle is always alive
  `PLI_NEVER(a_life_pos, out_valid && (out_new_life_left == '0), "dead particle delivered")
  // an accepted request lands in the first stage
  `PLI_NEXT(a_in_load, in_valid && !in_stall, vld_r[0], "request lost at entry")
  // eased factor stays within one
  `PLI_NEVER(a_ease_rng, vld_r[ST_EASE] && (st_r[ST_EASE].e > (FRAC_BITS+1)'(ONE_I)),
             "eased value out of range")

endmodule
